@@ hw/rtl/obb_pkg.sv @@
// Shared widths, constants and control types for the oriented box overlap pipeline.
package obb_pkg;

    localparam int STAGES       = 5;
    localparam int COORD_W      = 32;
    localparam int AXIS_W       = 16;
    localparam int EXT_W        = 32;
    localparam int DIFF_W       = COORD_W + 1;
    localparam int AXPROD_W     = 2 * AXIS_W;
    localparam int KMAG_W       = 2 * AXIS_W;
    localparam int OFFPROD_W    = AXIS_W + DIFF_W;
    localparam int OFFSUM_W     = OFFPROD_W + 1;
    localparam int OFFMAG_W     = OFFPROD_W;
    localparam int EK_W         = EXT_W + KMAG_W;
    localparam int EXT_SHIFT    = 28;
    localparam int OFF_SHIFT    = 14;
    localparam int LHS_W        = OFFMAG_W + OFF_SHIFT;
    localparam int SUM_W        = EK_W + 1;
    localparam int NUM_AXES     = 4;

    typedef struct packed {
        logic ld_mid;
        logic ld_sum;
    } sep_ctl_t;

endpackage

@@ hw/rtl/obb_axis_sep.sv @@
// One candidate separating axis: projected offset against summed projected extents.
module obb_axis_sep (
    input  logic                                   clk,
    input  obb_pkg::sep_ctl_t                      ctl,
    input  logic signed [obb_pkg::OFFPROD_W-1:0]   off_x,
    input  logic signed [obb_pkg::OFFPROD_W-1:0]   off_y,
    input  logic        [obb_pkg::EXT_W-1:0]       ext_self,
    input  logic        [obb_pkg::EXT_W-1:0]       ext0,
    input  logic        [obb_pkg::KMAG_W-1:0]      kmag0,
    input  logic        [obb_pkg::EXT_W-1:0]       ext1,
    input  logic        [obb_pkg::KMAG_W-1:0]      kmag1,
    output logic                                   sep
);

    logic signed [obb_pkg::OFFSUM_W-1:0] off_sum;
    logic signed [obb_pkg::OFFSUM_W-1:0] off_neg;
    logic        [obb_pkg::OFFMAG_W-1:0] off_mag;

    logic        [obb_pkg::OFFMAG_W-1:0] lhs_reg;
    logic        [obb_pkg::EK_W-1:0]     ek0_reg;
    logic        [obb_pkg::EK_W-1:0]     ek1_reg;
    logic        [obb_pkg::EXT_W-1:0]    ext_reg;

    logic        [obb_pkg::SUM_W-1:0]    sum_next;
    logic        [obb_pkg::SUM_W-1:0]    sum_reg;
    logic        [obb_pkg::OFFMAG_W-1:0] lhs2_reg;
    logic        [obb_pkg::LHS_W-1:0]    lhs_aligned;

    assign off_sum = obb_pkg::OFFSUM_W'(off_x) + obb_pkg::OFFSUM_W'(off_y);
    assign off_neg = -off_sum;
    assign off_mag = off_sum[obb_pkg::OFFSUM_W-1] ? off_neg[obb_pkg::OFFMAG_W-1:0]
                                                   : off_sum[obb_pkg::OFFMAG_W-1:0];

    always_ff @(posedge clk)
    begin
        if (ctl.ld_mid)
        begin
            lhs_reg <= off_mag;
            ek0_reg <= obb_pkg::EK_W'(ext0) * obb_pkg::EK_W'(kmag0);
            ek1_reg <= obb_pkg::EK_W'(ext1) * obb_pkg::EK_W'(kmag1);
            ext_reg <= ext_self;
        end
    end

    assign sum_next = obb_pkg::SUM_W'({ext_reg, {obb_pkg::EXT_SHIFT{1'b0}}})
                    + obb_pkg::SUM_W'(ek0_reg)
                    + obb_pkg::SUM_W'(ek1_reg);

    always_ff @(posedge clk)
    begin
        if (ctl.ld_sum)
        begin
            sum_reg  <= sum_next;
            lhs2_reg <= lhs_reg;
        end
    end

    assign lhs_aligned = {lhs2_reg, {obb_pkg::OFF_SHIFT{1'b0}}};
    assign sep         = obb_pkg::SUM_W'(lhs_aligned) > sum_reg;

endmodule

@@ hw/rtl/obb2d_overlap_test.sv @@
// Top level: pipelined separating axis overlap test for two oriented 2D boxes.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------------------
//  in      | input     | in_valid / in_ready   | two boxes: center, axis_u, axis_v, extents
//  out     | output    | out_valid / out_ready | overlap
//
//  Five register stages: differences and axis products, axis dot magnitudes and offset
//  products, offset magnitudes and extent products, extent sums, compare. One request
//  enters per cycle while in_ready is high; out_valid rises once a request has been
//  loaded into the compare stage, and the result leaves while out_ready is high.
//  Reset clears only the stage valid bits. Each stage holds while its successor is
//  full and stalled, so bubbles close up behind a stalled output.
module obb2d_overlap_test (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] first_center,
    input  logic [31:0] first_axis_u,
    input  logic [31:0] first_axis_v,
    input  logic [63:0] first_half_sizes,
    input  logic [63:0] second_center,
    input  logic [31:0] second_axis_u,
    input  logic [31:0] second_axis_v,
    input  logic [63:0] second_half_sizes,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        overlap
);

    localparam int NA = obb_pkg::NUM_AXES;

    logic [obb_pkg::STAGES-1:0] vld_reg;
    logic [obb_pkg::STAGES-1:0] vld_next;
    logic [obb_pkg::STAGES-1:0] rdy;

    logic signed [obb_pkg::AXIS_W-1:0]    in_ax [NA];
    logic signed [obb_pkg::AXIS_W-1:0]    in_ay [NA];
    logic        [obb_pkg::EXT_W-1:0]     in_ext [NA];
    logic signed [obb_pkg::DIFF_W-1:0]    dx_next;
    logic signed [obb_pkg::DIFF_W-1:0]    dy_next;
    logic signed [obb_pkg::AXPROD_W-1:0]  ppx_next [NA];
    logic signed [obb_pkg::AXPROD_W-1:0]  ppy_next [NA];

    logic signed [obb_pkg::AXIS_W-1:0]    ax_reg [NA];
    logic signed [obb_pkg::AXIS_W-1:0]    ay_reg [NA];
    logic        [obb_pkg::EXT_W-1:0]     ext_reg [NA];
    logic signed [obb_pkg::DIFF_W-1:0]    dx_reg;
    logic signed [obb_pkg::DIFF_W-1:0]    dy_reg;
    logic signed [obb_pkg::AXPROD_W-1:0]  ppx_reg [NA];
    logic signed [obb_pkg::AXPROD_W-1:0]  ppy_reg [NA];

    logic signed [obb_pkg::AXPROD_W:0]    ksum [NA];
    logic signed [obb_pkg::AXPROD_W:0]    kneg [NA];
    logic        [obb_pkg::KMAG_W-1:0]    kmag_next [NA];

    logic        [obb_pkg::KMAG_W-1:0]    kmag_reg [NA];
    logic signed [obb_pkg::OFFPROD_W-1:0] opx_reg [NA];
    logic signed [obb_pkg::OFFPROD_W-1:0] opy_reg [NA];
    logic        [obb_pkg::EXT_W-1:0]     ext2_reg [NA];

    logic [NA-1:0]     sep;
    logic              overlap_reg;
    obb_pkg::sep_ctl_t sep_ctl;

    assign rdy[obb_pkg::STAGES-1] = ~vld_reg[obb_pkg::STAGES-1] | out_ready;
    for (genvar s = 0; s < obb_pkg::STAGES - 1; s++)
    begin : g_rdy
        assign rdy[s] = ~vld_reg[s] | rdy[s+1];
    end

    always_comb
    begin
        if (!rdy[0])
            vld_next[0] = vld_reg[0];
        else
            vld_next[0] = in_valid;
        for (int s = 1; s < obb_pkg::STAGES; s++)
        begin
            if (!rdy[s])
                vld_next[s] = vld_reg[s];
            else
                vld_next[s] = vld_reg[s-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[obb_pkg::STAGES-1];
    assign overlap   = overlap_reg;

    // axis order: first u, first v, second u, second v
    assign in_ax[0]  = first_axis_u[31:16];
    assign in_ay[0]  = first_axis_u[15:0];
    assign in_ax[1]  = first_axis_v[31:16];
    assign in_ay[1]  = first_axis_v[15:0];
    assign in_ax[2]  = second_axis_u[31:16];
    assign in_ay[2]  = second_axis_u[15:0];
    assign in_ax[3]  = second_axis_v[31:16];
    assign in_ay[3]  = second_axis_v[15:0];
    assign in_ext[0] = first_half_sizes[63:32];
    assign in_ext[1] = first_half_sizes[31:0];
    assign in_ext[2] = second_half_sizes[63:32];
    assign in_ext[3] = second_half_sizes[31:0];

    assign dx_next = obb_pkg::DIFF_W'($signed(second_center[63:32]))
                   - obb_pkg::DIFF_W'($signed(first_center[63:32]));
    assign dy_next = obb_pkg::DIFF_W'($signed(second_center[31:0]))
                   - obb_pkg::DIFF_W'($signed(first_center[31:0]));

    // pair order: (u1,u2) (u1,v2) (v1,u2) (v1,v2)
    for (genvar p = 0; p < NA; p++)
    begin : g_pair
        localparam int PA = p / 2;
        localparam int PB = 2 + p % 2;
        assign ppx_next[p] = obb_pkg::AXPROD_W'(in_ax[PA]) * obb_pkg::AXPROD_W'(in_ax[PB]);
        assign ppy_next[p] = obb_pkg::AXPROD_W'(in_ay[PA]) * obb_pkg::AXPROD_W'(in_ay[PB]);
        assign ksum[p] = (obb_pkg::AXPROD_W+1)'(ppx_reg[p])
                       + (obb_pkg::AXPROD_W+1)'(ppy_reg[p]);
        assign kneg[p] = -ksum[p];
        assign kmag_next[p] = ksum[p][obb_pkg::AXPROD_W] ? kneg[p][obb_pkg::KMAG_W-1:0]
                                                          : ksum[p][obb_pkg::KMAG_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
            for (int i = 0; i < NA; i++)
            begin
                ax_reg[i]  <= in_ax[i];
                ay_reg[i]  <= in_ay[i];
                ext_reg[i] <= in_ext[i];
                ppx_reg[i] <= ppx_next[i];
                ppy_reg[i] <= ppy_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            for (int i = 0; i < NA; i++)
            begin
                kmag_reg[i] <= kmag_next[i];
                opx_reg[i]  <= obb_pkg::OFFPROD_W'(ax_reg[i]) * obb_pkg::OFFPROD_W'(dx_reg);
                opy_reg[i]  <= obb_pkg::OFFPROD_W'(ay_reg[i]) * obb_pkg::OFFPROD_W'(dy_reg);
                ext2_reg[i] <= ext_reg[i];
            end
        end
    end

    assign sep_ctl.ld_mid = rdy[2];
    assign sep_ctl.ld_sum = rdy[3];

    obb_axis_sep u_sep_a0 (
        .clk      (clk),
        .ctl      (sep_ctl),
        .off_x    (opx_reg[0]),
        .off_y    (opy_reg[0]),
        .ext_self (ext2_reg[0]),
        .ext0     (ext2_reg[2]),
        .kmag0    (kmag_reg[0]),
        .ext1     (ext2_reg[3]),
        .kmag1    (kmag_reg[1]),
        .sep      (sep[0])
    );

    obb_axis_sep u_sep_a1 (
        .clk      (clk),
        .ctl      (sep_ctl),
        .off_x    (opx_reg[1]),
        .off_y    (opy_reg[1]),
        .ext_self (ext2_reg[1]),
        .ext0     (ext2_reg[2]),
        .kmag0    (kmag_reg[2]),
        .ext1     (ext2_reg[3]),
        .kmag1    (kmag_reg[3]),
        .sep      (sep[1])
    );

    obb_axis_sep u_sep_b0 (
        .clk      (clk),
        .ctl      (sep_ctl),
        .off_x    (opx_reg[2]),
        .off_y    (opy_reg[2]),
        .ext_self (ext2_reg[2]),
        .ext0     (ext2_reg[0]),
        .kmag0    (kmag_reg[0]),
        .ext1     (ext2_reg[1]),
        .kmag1    (kmag_reg[2]),
        .sep      (sep[2])
    );

    obb_axis_sep u_sep_b1 (
        .clk      (clk),
        .ctl      (sep_ctl),
        .off_x    (opx_reg[3]),
        .off_y    (opy_reg[3]),
        .ext_self (ext2_reg[3]),
        .ext0     (ext2_reg[0]),
        .kmag0    (kmag_reg[1]),
        .ext1     (ext2_reg[1]),
        .kmag1    (kmag_reg[3]),
        .sep      (sep[3])
    );

    always_ff @(posedge clk)
    begin
        if (rdy[4])
            overlap_reg <= ~(|sep);
    end

endmodule
